// ----- rtl/frw_pkg.sv -----
// Shared types and constants for the FIFO-replacement identifier window.
`default_nettype none

package frw_pkg;

  localparam int ID_W  = 32;
  localparam int CAP_W = 6;

  localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

  // Input mode codes
  localparam logic MODE_MSG  = 1'b0;
  localparam logic MODE_DUMP = 1'b1;

  // Result kind codes
  localparam logic KIND_COUNT = 1'b0;
  localparam logic KIND_ID    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_DRAIN
  } frw_state_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // shift toward the old end, new id enters cell 0
    logic drn;  // shift toward cell 0, one entry leaves per step
  } frw_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/frw_cell.sv -----
// One cell of the identifier window: stored id, valid bit and match compare.
`default_nettype none

module frw_cell import frw_pkg::*; #(
  parameter int IDX   = 0,
  parameter int CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire frw_ctl_t         ctl,
  input  wire logic [CNT_W-1:0] count_next,
  input  wire logic [ID_W-1:0]  probe,
  input  wire logic [ID_W-1:0]  left_id,
  input  wire logic [ID_W-1:0]  right_id,
  input  wire logic             right_valid,
  output logic      [ID_W-1:0]  id,
  output logic                  valid,
  output logic                  hit
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      id <= left_id;
    end else if (ctl.drn) begin
      id <= right_id;
    end
  end

  // valid stays a thermometer of the held count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.ins) begin
      valid <= (MY_IDX < count_next);
    end else if (ctl.drn) begin
      valid <= right_valid;
    end
  end

  assign hit = valid && (id == probe);

endmodule

`default_nettype wire

// ----- rtl/fifo_replacement_id_window_top.sv -----
// Top level of the FIFO-replacement identifier window: cell chain and dump sequencer.
// Message item: accepted whenever idle, and input stays ready after it; no result.
// Dump item: count result valid in the cycle after acceptance, then one held id per
//   output handshake, newest first; n held entries give n+1 results.
// Input is not accepted while a dump is being delivered.
// Reset: every cell invalid, held count zero, capacity 32.
`default_nettype none

module fifo_replacement_id_window_top import frw_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             mode,
  input  wire logic [ID_W-1:0]  ident,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  kind,
  output logic      [ID_W-1:0]  value,
  output logic                  last
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT   = CNT_W'(1);

  // capacity register
  logic [CAP_W-1:0] capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // clamp into 1..DEPTH
  logic [CAP_W-1:0] eff_cap;

  always_comb begin
    eff_cap = capacity;
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > DEPTH_CAP) begin
      eff_cap = DEPTH_CAP;
    end
  end

  // ---------------- control ----------------
  frw_state_t       state, state_next;
  logic [CNT_W-1:0] held_count, held_count_next;
  logic             in_acc, out_acc, any_hit, full;
  frw_ctl_t         ctl;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign full    = CAP_W'(held_count) >= eff_cap;

  // new id enters only on a miss; drain shifts once per delivered id
  assign ctl.ins = in_acc && (mode == MODE_MSG) && !any_hit;
  assign ctl.drn = out_acc && (state == ST_DRAIN);

  always_comb begin
    held_count_next = held_count;
    if (ctl.ins) begin
      // at capacity one oldest entry drops, so the count holds
      held_count_next = full ? held_count : held_count + ONE_CNT;
    end else if (ctl.drn) begin
      held_count_next = held_count - ONE_CNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      held_count <= '0;
    end else begin
      state      <= state_next;
      held_count <= held_count_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_DUMP)) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        if (out_acc) begin
          state_next = (held_count == '0) ? ST_IDLE : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_acc && (held_count == ONE_CNT)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- cell chain ----------------
  logic [ID_W-1:0]  cell_id [DEPTH];
  logic [DEPTH-1:0] cell_vld;
  logic [DEPTH-1:0] cell_hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] left_id, right_id;
    logic            right_valid;

    if (i == 0) begin : g_head
      assign left_id = ident;
    end else begin : g_body
      assign left_id = cell_id[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_id    = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_id    = cell_id[i+1];
      assign right_valid = cell_vld[i+1];
    end

    frw_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .count_next  (held_count_next),
      .probe       (ident),
      .left_id     (left_id),
      .right_id    (right_id),
      .right_valid (right_valid),
      .id          (cell_id[i]),
      .valid       (cell_vld[i]),
      .hit         (cell_hit[i])
    );
  end

  assign any_hit = |cell_hit;

  // ---------------- outputs ----------------
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    kind      = KIND_COUNT;
    value     = ID_W'(held_count);
    last      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_COUNT: begin
        out_valid = 1'b1;
        last      = (held_count == '0);
      end
      ST_DRAIN: begin
        out_valid = 1'b1;
        kind      = KIND_ID;
        value     = cell_id[0];
        last      = (held_count == ONE_CNT);
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // ---------------- checks ----------------
  a_vld_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_vld) == int'(held_count))
    else $error("cell valid bits disagree with held count");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(held_count) <= DEPTH)
    else $error("held count beyond depth");

  a_insert_front: assert property (@(posedge clk) disable iff (rst)
    ctl.ins |=> (cell_vld[0] && (cell_id[0] == $past(ident))))
    else $error("new id not placed in front cell");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input open while dump in progress");

  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    ctl.drn |=> (held_count == CNT_W'($past(held_count) - ONE_CNT)))
    else $error("drain step did not drop count by one");

endmodule

`default_nettype wire

// ----- test/frw_window_checker.sv -----
// Checker for the identifier window: tracks held ids, predicts dump results, compares.
`timescale 1ns / 1ps

module frw_window_checker import frw_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic             mode,
  input  logic [ID_W-1:0]  ident,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic             kind,
  input  logic [ID_W-1:0]  value,
  input  logic             last,
  output int               mismatch_count,
  output int               results_owed
);

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] value;
    logic            last;
  } window_result_t;

  logic [ID_W-1:0]  held_ids[DEPTH];
  int unsigned      held_n;
  logic [CAP_W-1:0] cap_reg;
  window_result_t   owed[$];

  initial begin
    mismatch_count = 0;
    results_owed   = 0;
    held_n         = 0;
    cap_reg        = CAP_RESET;
  end

  // new id goes in front; full window (or one over a lowered capacity) drops its oldest
  function automatic void window_admit(logic [ID_W-1:0] id);
    int unsigned lim;
    bit          hit;
    hit = 1'b0;
    for (int i = 0; i < held_n; i++)
      if (held_ids[i] == id) hit = 1'b1;
    if (hit) return;
    lim = cap_reg;
    if (lim < 1) lim = 1;
    if (lim > DEPTH) lim = DEPTH;
    if (held_n >= lim && held_n > 0) held_n--;
    if (held_n >= DEPTH) held_n = DEPTH - 1;
    for (int i = held_n; i > 0; i--) held_ids[i] = held_ids[i-1];
    held_ids[0] = id;
    held_n++;
  endfunction

  function automatic void window_dump();
    window_result_t r;
    r.kind  = KIND_COUNT;
    r.value = held_n;
    r.last  = (held_n == 0);
    owed.push_back(r);
    for (int i = 0; i < held_n; i++) begin
      r.kind  = KIND_ID;
      r.value = held_ids[i];
      r.last  = (i + 1 == held_n);
      owed.push_back(r);
    end
    held_n = 0;
  endfunction

  always @(posedge clk) begin
    window_result_t e;
    if (rst) begin
      held_n  = 0;
      cap_reg = CAP_RESET;
      owed.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (owed.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected result kind=%0d value=%h last=%0d",
                     $time, kind, value, last);
          mismatch_count++;
        end else begin
          e = owed.pop_front();
          if (kind !== e.kind || value !== e.value || last !== e.last) begin
            if (mismatch_count < 10)
              $display("%0t: result mismatch: kind exp %0d act %0d, value exp %h act %h, last exp %0d act %0d",
                       $time, e.kind, kind, e.value, value, e.last, last);
            mismatch_count++;
          end
        end
      end
      if (cfg_we) cap_reg = cfg_wdata;
      if (in_valid && in_ready) begin
        if (mode == MODE_DUMP) window_dump();
        else window_admit(ident);
      end
    end
    results_owed = owed.size();
  end

endmodule

// ----- test/fifo_replacement_id_window_top_tb.sv -----
// Testbench top for the identifier window: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module fifo_replacement_id_window_top_tb;
  import frw_pkg::*;

  localparam int DEPTH      = 32;
  localparam int IDLE_LIMIT = 2000;  // cycles with no handshake before giving up
  localparam int LONG_HOLD  = 80;    // receiver hold-off, long enough to back up a dump

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             cfg_we    = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic             mode      = MODE_MSG;
  logic [ID_W-1:0]  ident     = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic             kind;
  logic [ID_W-1:0]  value;
  logic             last;

  int               fail_total;
  int               results_owed;

  // idle controls for both sides; rx_long_req asks the receiver for one long hold-off
  bit               tx_gaps_on  = 1'b1;
  bit               rx_gaps_on  = 1'b1;
  bit               rx_long_req = 1'b0;
  int unsigned      rx_stall_left = 0;
  int unsigned      idle_cycles   = 0;

  // small per-phase pool of ids so that repeats (hits) are common
  logic [ID_W-1:0]  id_pool[8];

  fifo_replacement_id_window_top #(.DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .ident     (ident),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value),
    .last      (last)
  );

  frw_window_checker #(.DEPTH(DEPTH)) window_check (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .mode           (mode),
    .ident          (ident),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .value          (value),
    .last           (last),
    .mismatch_count (fail_total),
    .results_owed   (results_owed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Receiver: one out_ready assignment per edge. A stall is a countdown, either a
  // short random burst or the single long hold-off that the stimulus asks for.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_stall_left == 0) begin
        if (rx_long_req) begin
          rx_stall_left = LONG_HOLD;
          rx_long_req   = 1'b0;
        end else if (rx_gaps_on && $urandom_range(0, 4) == 0) begin
          rx_stall_left = $urandom_range(1, 3);
        end
      end
      if (rx_stall_left != 0) begin
        out_ready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any handshake or config write restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item and hold it until taken. Entered and left at a rising edge;
  // valid only drops when a gap is inserted, so it is never lowered and raised
  // in the same step.
  task automatic offer_item(input logic m, input logic [ID_W-1:0] id);
    if (tx_gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    ident    <= id;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering, wait for every owed result, then let the block settle.
  // Owed count is looked at on the falling edge, after the checker has updated it.
  task automatic await_idle_window();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic under one capacity: pool hits, fresh ids, occasional dumps,
  // always closed by a dump so each phase reports what it built.
  task automatic run_random_phase(input logic [CAP_W-1:0] cap, input int unsigned n_items,
                                  input int unsigned dump_odds);
    await_idle_window();
    write_capacity(cap);
    for (int p = 0; p < 8; p++) id_pool[p] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(1, dump_odds) == 1)
        offer_item(MODE_DUMP, $urandom);
      else if ($urandom_range(0, 1) == 0)
        offer_item(MODE_MSG, id_pool[$urandom_range(0, 7)]);
      else
        offer_item(MODE_MSG, $urandom);
    end
    offer_item(MODE_DUMP, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty dump (ident ignored), extreme ids, a repeat, then a dump.
    write_capacity(6'd32);
    offer_item(MODE_DUMP, 32'hFFFF_FFFF);
    offer_item(MODE_MSG,  32'h0000_0000);
    offer_item(MODE_MSG,  32'hFFFF_FFFF);
    offer_item(MODE_MSG,  32'h0000_0000);
    offer_item(MODE_MSG,  32'h8000_0000);
    offer_item(MODE_MSG,  32'h0000_0001);
    offer_item(MODE_DUMP, 32'h0000_0000);

    // Capacity zero acts as one: only the newest id survives.
    await_idle_window();
    write_capacity(6'd0);
    offer_item(MODE_MSG,  32'h0000_0011);
    offer_item(MODE_MSG,  32'h0000_0022);
    offer_item(MODE_MSG,  32'h0000_0033);
    offer_item(MODE_DUMP, 32'h0);

    // Capacity dropped below the held count: each new id swaps out one oldest,
    // count stays at six; the evicted id then comes back as new.
    await_idle_window();
    write_capacity(6'd32);
    for (int i = 0; i < 6; i++) offer_item(MODE_MSG, 32'h0000_0100 + i);
    await_idle_window();
    write_capacity(6'd2);
    offer_item(MODE_MSG,  32'h0000_0200);
    offer_item(MODE_MSG,  32'h0000_0100);
    offer_item(MODE_MSG,  32'h0000_0103);
    offer_item(MODE_DUMP, 32'h0);

    // Backpressure: receiver holds off while a dump is pending, sender keeps
    // offering ids, which the block has to stall behind the dump.
    await_idle_window();
    write_capacity(6'd63);
    for (int i = 0; i < 5; i++) offer_item(MODE_MSG, $urandom);
    rx_long_req = 1'b1;
    offer_item(MODE_DUMP, 32'h0);
    for (int i = 0; i < 4; i++) offer_item(MODE_MSG, $urandom);
    offer_item(MODE_DUMP, 32'h0);

    // Random phases under a range of capacities, from zero up to 63.
    run_random_phase(6'd1,  30, 8);
    run_random_phase(6'd32, 50, 40);
    run_random_phase(6'd4,  30, 8);
    run_random_phase(6'd63, 50, 40);
    run_random_phase(6'd0,  30, 8);
    run_random_phase(6'd7,  30, 10);
    run_random_phase(6'd17, 30, 15);
    run_random_phase(6'd2,  30, 6);

    // Final stretch at full rate on both sides.
    await_idle_window();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    run_random_phase(6'd31, 30, 12);

    await_idle_window();
    repeat (8) @(posedge clk);
    if (fail_total == 0 && results_owed == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
